@@ rtl/ccs_pkg.sv @@
// shared types and character constants for the comment stripper
`default_nettype none

package ccs_pkg;

    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // result queue depth: one waiting result plus a two-result request
    localparam int QUEUE_DEPTH = 3;

    typedef enum logic [2:0] {
        MODE_NORMAL     = 3'd0,
        MODE_SLASH      = 3'd1,
        MODE_LINE       = 3'd2,
        MODE_BLOCK      = 3'd3,
        MODE_BLOCK_STAR = 3'd4
    } ccs_mode_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_text;
    } ccs_in_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last_of_run;
    } ccs_out_t;

endpackage

`default_nettype wire

@@ rtl/c_comment_stripper_unit.sv @@
// top level of the c comment stripper: scanner state machine and result queue
// each accepted result is registered in the queue and reaches m_data in order
// throughput: one request per cycle while results are taken as they appear
// a request that yields two results (held slash plus a byte) stalls the next request;
// s_ready decodes the queue count, high while at most one result waits
// reset (aresetn low, synchronous): queue emptied, scanner back to normal text
`default_nettype none

module c_comment_stripper_unit (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  ccs_pkg::ccs_in_t  s_data,
    output logic              m_valid,
    input  wire               m_ready,
    output ccs_pkg::ccs_out_t m_data
);

    // scanner state
    ccs_pkg::ccs_mode_t mode_reg, mode_next;
    // no byte kept yet on this line; "line has content" is always its inverse
    logic               at_line_start_reg, at_line_start_next;

    // result queue, head at entry 0
    ccs_pkg::ccs_out_t  q_reg [ccs_pkg::QUEUE_DEPTH];
    ccs_pkg::ccs_out_t  q_next [ccs_pkg::QUEUE_DEPTH];
    logic [1:0]         count_reg, count_next;

    // results produced by the request on the input
    logic [1:0]         res_n;
    ccs_pkg::ccs_out_t  res0, res1;

    logic               s_fire, m_fire;
    logic [1:0]         base;
    logic [1:0]         push_n;
    logic [7:0]         c;
    logic               is_blank;

    assign c        = s_data.char_in;
    assign is_blank = (c == ccs_pkg::CHAR_SPACE) || (c == ccs_pkg::CHAR_TAB)
                      || (c == ccs_pkg::CHAR_CR);

    // room for a full two-result request whatever the consumer does
    assign s_ready = (count_reg <= 2'd1);
    assign m_valid = (count_reg != 2'd0);
    assign m_data  = q_reg[0];
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;

    // next state of the scanner
    always_comb begin
        mode_next          = mode_reg;
        at_line_start_next = at_line_start_reg;
        if (s_data.end_of_text) begin
            // flush and return to reset state, abandoning any open comment
            mode_next          = ccs_pkg::MODE_NORMAL;
            at_line_start_next = 1'b1;
        end else begin
            unique case (mode_reg)
                ccs_pkg::MODE_SLASH: begin
                    if (c == ccs_pkg::CHAR_SLASH) begin
                        mode_next = ccs_pkg::MODE_LINE;
                    end else if (c == ccs_pkg::CHAR_STAR) begin
                        mode_next = ccs_pkg::MODE_BLOCK;
                    end else begin
                        // slash went out, then byte handled as normal text
                        mode_next          = ccs_pkg::MODE_NORMAL;
                        at_line_start_next = (c == ccs_pkg::CHAR_NL);
                    end
                end
                ccs_pkg::MODE_LINE: begin
                    if (c == ccs_pkg::CHAR_NL) begin
                        mode_next          = ccs_pkg::MODE_NORMAL;
                        at_line_start_next = 1'b1;
                    end
                end
                ccs_pkg::MODE_BLOCK: begin
                    if (c == ccs_pkg::CHAR_STAR) begin
                        mode_next = ccs_pkg::MODE_BLOCK_STAR;
                    end
                end
                ccs_pkg::MODE_BLOCK_STAR: begin
                    // extra stars keep waiting for the closing slash
                    if (c == ccs_pkg::CHAR_SLASH) begin
                        mode_next = ccs_pkg::MODE_NORMAL;
                    end else if (c != ccs_pkg::CHAR_STAR) begin
                        mode_next = ccs_pkg::MODE_BLOCK;
                    end
                end
                default: begin
                    // normal text, also covers unreachable codes
                    mode_next = ccs_pkg::MODE_NORMAL;
                    if (c == ccs_pkg::CHAR_SLASH) begin
                        mode_next = ccs_pkg::MODE_SLASH;
                    end else if (c == ccs_pkg::CHAR_NL) begin
                        at_line_start_next = 1'b1;
                    end else if (!is_blank) begin
                        at_line_start_next = 1'b0;
                    end
                end
            endcase
        end
    end

    // results of the scanner
    always_comb begin
        res_n = 2'd0;
        res0  = '{char_out: c, last_of_run: 1'b1};
        res1  = '{char_out: c, last_of_run: 1'b1};
        if (s_data.end_of_text) begin
            if (mode_reg == ccs_pkg::MODE_SLASH) begin
                res_n = 2'd1;
                res0  = '{char_out: ccs_pkg::CHAR_SLASH, last_of_run: 1'b1};
            end
        end else begin
            unique case (mode_reg) inside
                ccs_pkg::MODE_SLASH: begin
                    if (c != ccs_pkg::CHAR_SLASH && c != ccs_pkg::CHAR_STAR) begin
                        // held slash first; the line now has content, so
                        // any following byte (blank or newline) is kept
                        res_n = 2'd2;
                        res0  = '{char_out: ccs_pkg::CHAR_SLASH, last_of_run: 1'b0};
                    end else if (c == ccs_pkg::CHAR_SLASH) begin
                        res_n = 2'd0;
                    end
                end
                ccs_pkg::MODE_LINE: begin
                    if (c == ccs_pkg::CHAR_NL && !at_line_start_reg) begin
                        res_n = 2'd1;
                    end
                end
                ccs_pkg::MODE_BLOCK, ccs_pkg::MODE_BLOCK_STAR: begin
                    res_n = 2'd0;
                end
                default: begin
                    if (c == ccs_pkg::CHAR_SLASH) begin
                        res_n = 2'd0;
                    end else if (c == ccs_pkg::CHAR_NL || is_blank) begin
                        res_n = at_line_start_reg ? 2'd0 : 2'd1;
                    end else begin
                        res_n = 2'd1;
                    end
                end
            endcase
        end
    end

    // queue update: pop shifts toward the head, pushes land after survivors
    always_comb begin
        base       = count_reg - {1'b0, m_fire};
        push_n     = s_fire ? res_n : 2'd0;
        count_next = base + push_n;
        q_next[0]  = m_fire ? q_reg[1] : q_reg[0];
        q_next[1]  = m_fire ? q_reg[2] : q_reg[1];
        q_next[2]  = q_reg[2];
        for (int i = 0; i < ccs_pkg::QUEUE_DEPTH; i++) begin
            if (push_n != 2'd0 && base == 2'(i)) begin
                q_next[i] = res0;
            end
            if (push_n == 2'd2 && (base + 2'd1) == 2'(i)) begin
                q_next[i] = res1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= ccs_pkg::MODE_NORMAL;
            at_line_start_reg <= 1'b1;
            count_reg         <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (s_fire) begin
                mode_reg          <= mode_next;
                at_line_start_reg <= at_line_start_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < ccs_pkg::QUEUE_DEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

    // a non-final result always has its partner queued right behind it
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last_of_run |-> count_reg >= 2'd2)
        else $error("non-final result without its partner in the queue");

    // end of text always brings the scanner back to its reset state
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_data.end_of_text
        |=> mode_reg == ccs_pkg::MODE_NORMAL && at_line_start_reg)
        else $error("scanner not reset after end of text");

    // nothing inside a block comment reaches the output
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && !s_data.end_of_text
        && (mode_reg == ccs_pkg::MODE_BLOCK || mode_reg == ccs_pkg::MODE_BLOCK_STAR)
        |=> count_reg <= $past(count_reg))
        else $error("result pushed from inside a block comment");

    // the queue never overruns: an accepted request always fits
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |-> ({1'b0, base} + {1'b0, res_n}) <= 3'(ccs_pkg::QUEUE_DEPTH))
        else $error("result queue overrun");

endmodule

`default_nettype wire
